// ===== sv/assert_macros.svh =====
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define FGLW_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define FGLW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fglw_pkg.sv =====
// types, constants and the band table of the fuel gauge wiper drive
`timescale 1ns / 1ps

package fglw_pkg;

	localparam int unsigned LEVEL_W = 14;
	localparam int unsigned AGE_W   = 24;
	localparam int unsigned PER_W   = 16;
	localparam int unsigned NUM_W   = 22;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDATA_W = 24;

	localparam logic [CIDX_W-1:0] REG_LISTEN_ID    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_MAP_IN_LOW   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_MAP_IN_HIGH  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_MAP_OUT_LOW  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_MAP_OUT_HIGH = 3'd4;
	localparam logic [CIDX_W-1:0] REG_STALE_TICKS  = 3'd5;
	localparam logic [CIDX_W-1:0] REG_UPDATE_TICKS = 3'd6;

	localparam logic [10:0]        LISTEN_ID_RST    = 11'h391;
	localparam logic [7:0]         MAP_IN_LOW_RST   = 8'd0;
	localparam logic [7:0]         MAP_IN_HIGH_RST  = 8'd255;
	localparam logic [LEVEL_W-1:0] MAP_OUT_LOW_RST  = 14'd0;
	localparam logic [LEVEL_W-1:0] MAP_OUT_HIGH_RST = 14'd10000;
	localparam logic [AGE_W-1:0]   STALE_TICKS_RST  = 24'd60000;
	localparam logic [PER_W-1:0]   UPDATE_TICKS_RST = 16'd1000;
	localparam logic [LEVEL_W-1:0] FILL_LEVEL_RST   = 14'd5100;
	localparam logic [AGE_W-1:0]   AGE_MAX          = 24'hFFFFFF;

	localparam logic FUNC_FRAME = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef struct packed {
		logic tick;
		logic clr_age;
	} tick_ctl_t;

	typedef struct packed {
		logic period_end;
		logic stale;
	} tick_sts_t;

	// returns {wiper_b, wiper_a}
	function automatic logic [15:0] band_codes(input logic [LEVEL_W-1:0] lv);
		logic [15:0] r;
		if (lv < 14'd625)       r = {8'hFF, 8'hE9};
		else if (lv < 14'd1250) r = {8'hFE, 8'hF2};
		else if (lv < 14'd1875) r = {8'hFE, 8'hF5};
		else if (lv < 14'd2500) r = {8'hFD, 8'hF6};
		else if (lv < 14'd3750) r = {8'hFC, 8'hF7};
		else if (lv < 14'd5000) r = {8'hFC, 8'hFA};
		else if (lv < 14'd6250) r = {8'hFB, 8'hFB};
		else if (lv < 14'd7500) r = {8'hF8, 8'hFC};
		else if (lv < 14'd8750) r = {8'hF7, 8'hFE};
		else if (lv < 14'd9500) r = {8'hF5, 8'hFF};
		else                    r = {8'hE9, 8'hFF};
		return r;
	endfunction

endpackage

// ===== sv/fglw_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fglw_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fglw_pkg::NUM_W-1:0]  dividend,
	input  logic [7:0]                  divisor,
	output logic                        done,
	output logic [fglw_pkg::NUM_W-1:0]  quotient
);

	localparam int unsigned CNT_W = $clog2(fglw_pkg::NUM_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [7:0]                  rem_q;
	logic [7:0]                  dvs_q;
	logic [fglw_pkg::NUM_W-1:0]  quo_q;
	logic [8:0]                  trial;
	logic                        fits;
	logic [8:0]                  diff;

	assign trial = {rem_q, quo_q[fglw_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(fglw_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[7:0] : trial[7:0];
			quo_q <= {quo_q[fglw_pkg::NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/fglw_tick.sv =====
// frame age and update period counters
`timescale 1ns / 1ps

module fglw_tick (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fglw_pkg::tick_ctl_t          ctl,
	input  logic [fglw_pkg::AGE_W-1:0]   stale_ticks,
	input  logic [fglw_pkg::PER_W-1:0]   update_ticks,
	output fglw_pkg::tick_sts_t          sts
);

	logic [fglw_pkg::AGE_W-1:0] age_q;
	logic [fglw_pkg::PER_W-1:0] period_q;
	logic [fglw_pkg::AGE_W-1:0] age_next;
	logic [fglw_pkg::PER_W-1:0] period_next;
	logic [fglw_pkg::PER_W-1:0] limit;

	assign age_next    = (age_q == fglw_pkg::AGE_MAX) ? age_q : age_q + 1'b1;
	assign period_next = period_q + 1'b1;
	assign limit       = (update_ticks == '0) ? fglw_pkg::PER_W'(1) : update_ticks;

	assign sts.period_end = period_next >= limit;
	assign sts.stale      = age_next >= stale_ticks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q    <= '0;
			period_q <= '0;
		end else if (ctl.clr_age) begin
			age_q <= '0;
		end else if (ctl.tick) begin
			age_q    <= age_next;
			period_q <= sts.period_end ? '0 : period_next;
		end
	end

endmodule

// ===== sv/fuel_gauge_level_to_wiper_drive_top.sv =====
// top level: sequencer, configuration registers, level mapping and output register
// a tick or a frame that needs no division passes from accept through ST_EXEC and ST_OUT to the output register;
// a frame mapped by interpolation also waits in ST_DIV for the 22 steps of the divider
// one word in work at a time: s_tready is high only in ST_IDLE, and ST_OUT holds while the output stalls
// arst_n clears control, counters, level (5100) and configuration registers to their defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fuel_gauge_level_to_wiper_drive_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // frame_id[10:0], frame_byte[18:11], zero
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // level[13:0], wiper_a[21:14], wiper_b[29:22], zero
	output logic [1:0]  m_tuser,   // send_echo[0], wiper_update[1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [fglw_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [fglw_pkg::CDATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_OUT} state_t;

	state_t                          state_q;
	logic [10:0]                     listen_id_q;
	logic [7:0]                      in_low_q;
	logic [7:0]                      in_high_q;
	logic [fglw_pkg::LEVEL_W-1:0]    out_low_q;
	logic [fglw_pkg::LEVEL_W-1:0]    out_high_q;
	logic [fglw_pkg::AGE_W-1:0]      stale_ticks_q;
	logic [fglw_pkg::PER_W-1:0]      update_ticks_q;

	logic                            func_q;
	logic [10:0]                     id_q;
	logic [7:0]                      byte_q;
	logic [fglw_pkg::LEVEL_W-1:0]    fill_q;
	logic                            echo_q;
	logic                            upd_q;
	logic [7:0]                      wa_q;
	logic [7:0]                      wb_q;
	logic                            m_tvalid_q;
	logic [31:0]                     m_tdata_q;
	logic [1:0]                      m_tuser_q;

	logic                            below;
	logic                            above;
	logic [7:0]                      span;
	logic [7:0]                      offset;
	logic                            down;
	logic [fglw_pkg::LEVEL_W-1:0]    out_diff;
	logic [fglw_pkg::NUM_W-1:0]      product;
	logic                            id_match;
	logic                            div_start;
	logic                            div_done;
	logic [fglw_pkg::NUM_W-1:0]      div_quo;
	logic [fglw_pkg::LEVEL_W-1:0]    quo14;
	logic [fglw_pkg::LEVEL_W-1:0]    mapped;
	logic [fglw_pkg::LEVEL_W-1:0]    tick_level;
	logic [15:0]                     band;
	logic                            out_free;
	fglw_pkg::tick_ctl_t             tick_ctl;
	fglw_pkg::tick_sts_t             tick_sts;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_id_q    <= fglw_pkg::LISTEN_ID_RST;
			in_low_q       <= fglw_pkg::MAP_IN_LOW_RST;
			in_high_q      <= fglw_pkg::MAP_IN_HIGH_RST;
			out_low_q      <= fglw_pkg::MAP_OUT_LOW_RST;
			out_high_q     <= fglw_pkg::MAP_OUT_HIGH_RST;
			stale_ticks_q  <= fglw_pkg::STALE_TICKS_RST;
			update_ticks_q <= fglw_pkg::UPDATE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fglw_pkg::REG_LISTEN_ID:    listen_id_q    <= cfg_data[10:0];
				fglw_pkg::REG_MAP_IN_LOW:   in_low_q       <= cfg_data[7:0];
				fglw_pkg::REG_MAP_IN_HIGH:  in_high_q      <= cfg_data[7:0];
				fglw_pkg::REG_MAP_OUT_LOW:  out_low_q      <= cfg_data[13:0];
				fglw_pkg::REG_MAP_OUT_HIGH: out_high_q     <= cfg_data[13:0];
				fglw_pkg::REG_STALE_TICKS:  stale_ticks_q  <= cfg_data[23:0];
				fglw_pkg::REG_UPDATE_TICKS: update_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// mapping datapath
	assign below    = byte_q < in_low_q;
	assign above    = byte_q > in_high_q;
	assign span     = in_high_q - in_low_q;
	assign offset   = byte_q - in_low_q;
	assign down     = out_high_q < out_low_q;
	assign out_diff = down ? out_low_q - out_high_q : out_high_q - out_low_q;
	assign product  = fglw_pkg::NUM_W'(offset * out_diff);
	assign id_match = (func_q == fglw_pkg::FUNC_FRAME) && (id_q == listen_id_q);

	assign div_start = (state_q == ST_EXEC) && id_match && !below && !above && (span != '0);

	fglw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (span),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign quo14  = div_quo[fglw_pkg::LEVEL_W-1:0];
	assign mapped = down ? out_low_q - quo14 : out_low_q + quo14;

	// tick counters
	assign tick_ctl.tick    = (state_q == ST_EXEC) && (func_q == fglw_pkg::FUNC_TICK);
	assign tick_ctl.clr_age = (state_q == ST_EXEC) && id_match;

	fglw_tick u_tick (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (tick_ctl),
		.stale_ticks  (stale_ticks_q),
		.update_ticks (update_ticks_q),
		.sts          (tick_sts)
	);

	assign tick_level = tick_sts.stale ? '0 : fill_q;
	assign band       = fglw_pkg::band_codes(tick_level);
	assign out_free   = !m_tvalid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= fglw_pkg::FILL_LEVEL_RST;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						func_q  <= s_tuser;
						id_q    <= s_tdata[10:0];
						byte_q  <= s_tdata[18:11];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					echo_q  <= 1'b0;
					upd_q   <= 1'b0;
					wa_q    <= '0;
					wb_q    <= '0;
					state_q <= ST_OUT;
					if (func_q == fglw_pkg::FUNC_TICK) begin
						if (tick_sts.period_end) begin
							fill_q <= tick_level;
							upd_q  <= 1'b1;
							wa_q   <= band[7:0];
							wb_q   <= band[15:8];
						end
					end else begin
						echo_q <= 1'b1;
						if (id_match) begin
							if (below) begin
								fill_q <= out_low_q;
							end else if (above) begin
								fill_q <= out_high_q;
							end else if (span == '0) begin
								fill_q <= out_low_q;
							end else begin
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						fill_q  <= mapped;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, wb_q, wa_q, fill_q};
						m_tuser_q  <= {upd_q, echo_q};
						state_q    <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`FGLW_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "word taken while busy")
	`FGLW_ASSERT_NOW(a_kind_excl, !m_tvalid || !(m_tuser[0] && m_tuser[1]), "echo and update both set")
	`FGLW_ASSERT_NOW(a_wiper_zero, !m_tvalid || m_tuser[1] || (m_tdata[29:14] == '0), "wiper codes without update")
	`FGLW_ASSERT_NOW(a_div_state, !div_done || (state_q == ST_DIV), "divider done outside division")

endmodule
